// ===== sv/cdq_pkg.sv =====
// shared constants and types for the circular double-ended queue
package cdq_pkg;

  localparam int DEPTH = 16;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int FUNC_W = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [AW-1:0]     idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic signed [DW-1:0] data_t;

  localparam func_t FUNC_PUSH_FRONT = 2'd0;
  localparam func_t FUNC_PUSH_REAR  = 2'd1;
  localparam func_t FUNC_POP_FRONT  = 2'd2;
  localparam func_t FUNC_POP_REAR   = 2'd3;

  localparam data_t NEG_ONE = '1;

endpackage

// ===== sv/cdq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/circular_double_ended_queue.sv =====
// Double-ended queue over a circular slot ram. One request is taken at a time.
// A push, a refused request, or a pop that empties the queue returns its
// result in the cycle after acceptance; a pop that leaves entries first
// passes through the S_POP state for the registered ram read of the new
// front or rear slot. The front and rear entries are cached in
// registers, the slots themselves live in the ram. A capacity write empties
// the queue; slot contents are kept but never read before being rewritten.
module circular_double_ended_queue
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_capacity,
  input  logic             in_valid,
  output logic             in_stall,
  input  func_t            in_func,
  input  data_t            in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_accepted,
  output data_t            out_popped_value,
  output data_t            out_front_value,
  output data_t            out_rear_value,
  output logic             out_is_empty,
  output logic             out_is_full
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic  state_r, state_nxt;
  cnt_t  cap_r, cap_nxt;
  cnt_t  occ_r, occ_nxt;
  idx_t  head_r, head_nxt;
  idx_t  tail_r, tail_nxt;
  data_t front_r, front_nxt;
  data_t rear_r, rear_nxt;
  logic  pop_front_r, pop_front_nxt;
  data_t popped_r, popped_nxt;

  logic  out_valid_r, out_valid_nxt;
  logic  out_accepted_r, out_accepted_nxt;
  data_t out_popped_r, out_popped_nxt;
  data_t out_front_r, out_front_nxt;
  data_t out_rear_r, out_rear_nxt;
  logic  out_empty_r, out_empty_nxt;
  logic  out_full_r, out_full_nxt;

  logic  out_free;
  logic  accept;
  logic  is_push;
  idx_t  cap_last;
  idx_t  head_inc, head_dec, tail_inc, tail_dec;
  logic  ram_wr_en, ram_rd_en;
  idx_t  ram_wr_addr, ram_rd_addr;
  data_t ram_rd_data;
  cnt_t  cap_eff;

  cdq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(in_value),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign is_push  = !in_func[1];

  assign cap_last = AW'(cap_r - cnt_t'(1));
  assign head_inc = ((cnt_t'(head_r) + cnt_t'(1)) >= cap_r) ? '0 : AW'(head_r + idx_t'(1));
  assign tail_inc = ((cnt_t'(tail_r) + cnt_t'(1)) >= cap_r) ? '0 : AW'(tail_r + idx_t'(1));
  assign head_dec = (head_r == '0) ? cap_last : AW'(head_r - idx_t'(1));
  assign tail_dec = (tail_r == '0) ? cap_last : AW'(tail_r - idx_t'(1));

  always_comb begin
    priority if (cfg_capacity == '0) begin
      cap_eff = cnt_t'(1);
    end else if (int'(cfg_capacity) > DEPTH) begin
      cap_eff = cnt_t'(DEPTH);
    end else begin
      cap_eff = cnt_t'(cfg_capacity);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cap_nxt          = cap_r;
    occ_nxt          = occ_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    front_nxt        = front_r;
    rear_nxt         = rear_r;
    pop_front_nxt    = pop_front_r;
    popped_nxt       = popped_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_accepted_nxt = out_accepted_r;
    out_popped_nxt   = out_popped_r;
    out_front_nxt    = out_front_r;
    out_rear_nxt     = out_rear_r;
    out_empty_nxt    = out_empty_r;
    out_full_nxt     = out_full_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = '0;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = '0;

    if (cfg_wr_en) begin
      cap_nxt  = cap_eff;
      occ_nxt  = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end else if (accept) begin
      out_popped_nxt   = NEG_ONE;
      out_accepted_nxt = 1'b0;
      if (is_push) begin
        if (occ_r < cap_r) begin
          out_accepted_nxt = 1'b1;
          ram_wr_en        = 1'b1;
          occ_nxt          = occ_r + cnt_t'(1);
          if (occ_r == '0) begin
            head_nxt    = '0;
            tail_nxt    = '0;
            ram_wr_addr = '0;
            front_nxt   = in_value;
            rear_nxt    = in_value;
          end else if (in_func == FUNC_PUSH_FRONT) begin
            head_nxt    = head_dec;
            ram_wr_addr = head_dec;
            front_nxt   = in_value;
          end else begin
            tail_nxt    = tail_inc;
            ram_wr_addr = tail_inc;
            rear_nxt    = in_value;
          end
        end
        out_valid_nxt = 1'b1;
        out_front_nxt = (occ_nxt == '0) ? NEG_ONE : front_nxt;
        out_rear_nxt  = (occ_nxt == '0) ? NEG_ONE : rear_nxt;
        out_empty_nxt = (occ_nxt == '0);
        out_full_nxt  = (occ_nxt == cap_r);
      end else if (occ_r == '0) begin
        out_valid_nxt = 1'b1;
        out_front_nxt = NEG_ONE;
        out_rear_nxt  = NEG_ONE;
        out_empty_nxt = 1'b1;
        out_full_nxt  = (occ_r == cap_r);
      end else begin
        occ_nxt       = occ_r - cnt_t'(1);
        pop_front_nxt = (in_func == FUNC_POP_FRONT);
        popped_nxt    = (in_func == FUNC_POP_FRONT) ? front_r : rear_r;
        if (occ_r == cnt_t'(1)) begin
          head_nxt         = '0;
          tail_nxt         = '0;
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = 1'b1;
          out_popped_nxt   = popped_nxt;
          out_front_nxt    = NEG_ONE;
          out_rear_nxt     = NEG_ONE;
          out_empty_nxt    = 1'b1;
          out_full_nxt     = (cap_r == '0);
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_POP;
          if (in_func == FUNC_POP_FRONT) begin
            head_nxt    = head_inc;
            ram_rd_addr = head_inc;
          end else begin
            tail_nxt    = tail_dec;
            ram_rd_addr = tail_dec;
          end
        end
      end
    end else if (state_r == S_POP && out_free) begin
      if (pop_front_r) begin
        front_nxt = ram_rd_data;
      end else begin
        rear_nxt = ram_rd_data;
      end
      state_nxt        = S_IDLE;
      out_valid_nxt    = 1'b1;
      out_accepted_nxt = 1'b1;
      out_popped_nxt   = popped_r;
      out_front_nxt    = front_nxt;
      out_rear_nxt     = rear_nxt;
      out_empty_nxt    = 1'b0;
      out_full_nxt     = (occ_r == cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= cnt_t'(DEPTH);
      occ_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r        <= front_nxt;
    rear_r         <= rear_nxt;
    pop_front_r    <= pop_front_nxt;
    popped_r       <= popped_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_popped_r   <= out_popped_nxt;
    out_front_r    <= out_front_nxt;
    out_rear_r     <= out_rear_nxt;
    out_empty_r    <= out_empty_nxt;
    out_full_r     <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_rear_value   = out_rear_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

`ifndef SYNTHESIS
  a_occ_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_r)
    else $error("occupancy above capacity");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_t'(head_r) < cap_r) && (cnt_t'(tail_r) < cap_r))
    else $error("head or tail outside capacity");

  a_empty_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == '0) && (tail_r == '0))
    else $error("empty queue with nonzero indices");

  a_pop_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && out_free && !cfg_wr_en |=> out_valid_r && out_accepted_r
      && !out_empty_r)
    else $error("pending pop produced no accepted result");
`endif

endmodule
